FILE: hw/rtl/ps2hb_pkg.sv
// shared types and constants of the ps2 host bit engine
package ps2hb_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_RX      = 2'd1,
        MODE_INHIBIT = 2'd2,
        MODE_TX      = 2'd3
    } t_mode;

    localparam logic [1:0] KIND_EDGE = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_SEND = 2'd2;

    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_BYTE      = 3'd1;
    localparam logic [2:0] EV_ACKBYTE   = 3'd2;
    localparam logic [2:0] EV_SENT_ACK  = 3'd3;
    localparam logic [2:0] EV_SENT_NACK = 3'd4;
    localparam logic [2:0] EV_TIMEOUT   = 3'd5;
    localparam logic [2:0] EV_REJECT    = 3'd6;

    localparam logic CFG_TIMEOUT = 1'b0;
    localparam logic CFG_INHIBIT = 1'b1;

    localparam logic [7:0] ACK_CODE       = 8'hFA;
    localparam logic [2:0] TRAILER_FIXED  = 3'b110;
    localparam logic [7:0] COUNT_MAX      = 8'hFF;
    localparam logic [7:0] TIMEOUT_RESET  = 8'd48;
    localparam logic [7:0] INHIBIT_RESET  = 8'd2;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] frame_byte;
        logic [2:0] trailer_bits;
        logic       in_trailer;
        logic [7:0] bit_mask;
        logic       parity_acc;
        logic [7:0] idle_count;
        logic       timer_running;
        logic       data_low;
        logic       clock_low;
    } t_state;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] rx_byte;
        logic       data_drive_low;
        logic       clock_drive_low;
        logic       busy_res;
    } t_result;

    localparam t_state STATE_RESET = '{
        mode:          MODE_IDLE,
        frame_byte:    8'd0,
        trailer_bits:  3'd0,
        in_trailer:    1'b0,
        bit_mask:      8'd0,
        parity_acc:    1'b0,
        idle_count:    8'd0,
        timer_running: 1'b0,
        data_low:      1'b0,
        clock_low:     1'b0
    };

endpackage

FILE: hw/rtl/ps2hb_step.sv
// per-item next state and result logic of the ps2 host bit engine
module ps2hb_step (
    input  ps2hb_pkg::t_state  i_state,
    input  logic [7:0]         i_timeout_ticks,
    input  logic [7:0]         i_inhibit_ticks,
    input  logic [1:0]         i_kind,
    input  logic               i_data_level,
    input  logic [7:0]         i_send_byte,
    output ps2hb_pkg::t_state  o_state,
    output ps2hb_pkg::t_result o_result
);
    import ps2hb_pkg::*;

    t_state     n_st;
    logic [2:0] n_ev;
    logic [7:0] n_rx;

    // next state and event
    always_comb begin
        logic [7:0] mask_sh;
        logic [2:0] tmask_sh;
        logic       tx_bit;
        logic       par;
        logic [7:0] cnt;
        logic [7:0] fbyte;
        n_st     = i_state;
        n_ev     = EV_NONE;
        n_rx     = 8'd0;
        mask_sh  = {i_state.bit_mask[6:0], 1'b0};
        tmask_sh = {i_state.bit_mask[1:0], 1'b0};
        tx_bit   = |(i_state.frame_byte & i_state.bit_mask);
        par      = i_state.parity_acc;
        cnt      = i_state.idle_count + {7'd0, (i_state.idle_count != COUNT_MAX)};
        fbyte    = i_state.frame_byte;
        unique case (i_kind)
            KIND_EDGE: begin
                if (i_state.mode == MODE_TX) begin
                    n_st.idle_count    = 8'd0;
                    n_st.timer_running = 1'b1;
                    if (!i_state.in_trailer) begin
                        if (i_state.bit_mask == 8'd0) begin
                            n_st.parity_acc = 1'b0;
                            n_st.bit_mask   = 8'd1;
                        end else begin
                            par             = i_state.parity_acc ^ tx_bit;
                            n_st.data_low   = ~tx_bit;
                            n_st.parity_acc = par;
                            n_st.bit_mask   = mask_sh;
                            if (mask_sh == 8'd0) begin
                                n_st.in_trailer   = 1'b1;
                                n_st.bit_mask     = 8'd1;
                                n_st.trailer_bits = TRAILER_FIXED | {2'b00, ~par};
                            end
                        end
                    end else begin
                        n_st.data_low = ~|(i_state.trailer_bits & i_state.bit_mask[2:0]);
                        n_st.bit_mask = {5'd0, tmask_sh};
                        if (tmask_sh == 3'd0) begin
                            n_st.mode          = MODE_IDLE;
                            n_st.timer_running = 1'b0;
                            n_st.idle_count    = 8'd0;
                            n_st.bit_mask      = 8'd0;
                            n_st.in_trailer    = 1'b0;
                            n_st.trailer_bits  = 3'd0;
                            n_st.data_low      = 1'b0;
                            n_st.clock_low     = 1'b0;
                            n_ev = i_data_level ? EV_SENT_NACK : EV_SENT_ACK;
                        end
                    end
                end else if (i_state.mode == MODE_IDLE) begin
                    if (!i_data_level) begin
                        n_st.idle_count    = 8'd0;
                        n_st.timer_running = 1'b1;
                        n_st.mode          = MODE_RX;
                        n_st.frame_byte    = 8'd0;
                        n_st.parity_acc    = 1'b0;
                        n_st.bit_mask      = 8'd1;
                        n_st.in_trailer    = 1'b0;
                        n_st.trailer_bits  = 3'd0;
                    end
                end else if (i_state.mode == MODE_RX) begin
                    n_st.idle_count    = 8'd0;
                    n_st.timer_running = 1'b1;
                    if (!i_state.in_trailer) begin
                        if (i_data_level) begin
                            n_st.frame_byte = i_state.frame_byte | i_state.bit_mask;
                        end
                        n_st.parity_acc = i_state.parity_acc ^ i_data_level;
                        n_st.bit_mask   = mask_sh;
                        if (mask_sh == 8'd0) begin
                            n_st.in_trailer   = 1'b1;
                            n_st.bit_mask     = 8'd1;
                            n_st.trailer_bits = 3'd0;
                        end
                    end else if (i_state.bit_mask[0]) begin
                        if (i_data_level) begin
                            n_st.trailer_bits = i_state.trailer_bits | 3'd1;
                        end
                        n_st.parity_acc = i_state.parity_acc ^ i_data_level;
                        n_st.bit_mask   = 8'd2;
                    end else begin
                        n_st.mode          = MODE_IDLE;
                        n_st.timer_running = 1'b0;
                        n_st.idle_count    = 8'd0;
                        n_st.bit_mask      = 8'd0;
                        n_st.in_trailer    = 1'b0;
                        n_st.trailer_bits  = 3'd0;
                        n_st.data_low      = 1'b0;
                        n_st.clock_low     = 1'b0;
                        if (i_data_level && i_state.parity_acc) begin
                            n_rx = fbyte;
                            n_ev = (fbyte == ACK_CODE) ? EV_ACKBYTE : EV_BYTE;
                        end
                    end
                end
            end
            KIND_TICK: begin
                if (i_state.timer_running) begin
                    n_st.idle_count = cnt;
                    if (i_state.mode == MODE_INHIBIT) begin
                        if (cnt >= i_inhibit_ticks) begin
                            n_st.data_low      = 1'b1;
                            n_st.clock_low     = 1'b0;
                            n_st.mode          = MODE_TX;
                            n_st.bit_mask      = 8'd0;
                            n_st.in_trailer    = 1'b0;
                            n_st.parity_acc    = 1'b0;
                            n_st.idle_count    = 8'd0;
                            n_st.timer_running = 1'b1;
                        end
                    end else if (cnt >= i_timeout_ticks) begin
                        n_st.mode          = MODE_IDLE;
                        n_st.timer_running = 1'b0;
                        n_st.idle_count    = 8'd0;
                        n_st.bit_mask      = 8'd0;
                        n_st.in_trailer    = 1'b0;
                        n_st.trailer_bits  = 3'd0;
                        n_st.data_low      = 1'b0;
                        n_st.clock_low     = 1'b0;
                        n_ev = EV_TIMEOUT;
                    end
                end
            end
            KIND_SEND: begin
                if (i_state.mode != MODE_IDLE) begin
                    n_ev = EV_REJECT;
                end else begin
                    n_st.frame_byte    = i_send_byte;
                    n_st.mode          = MODE_INHIBIT;
                    n_st.clock_low     = 1'b1;
                    n_st.data_low      = 1'b0;
                    n_st.bit_mask      = 8'd0;
                    n_st.in_trailer    = 1'b0;
                    n_st.trailer_bits  = 3'd0;
                    n_st.parity_acc    = 1'b0;
                    n_st.idle_count    = 8'd0;
                    n_st.timer_running = 1'b1;
                end
            end
            default: begin
                n_ev = EV_NONE;
            end
        endcase
    end

    // result fields
    always_comb begin
        o_result.event_res       = n_ev;
        o_result.rx_byte         = n_rx;
        o_result.data_drive_low  = n_st.data_low;
        o_result.clock_drive_low = n_st.clock_low;
        o_result.busy_res        = (n_st.mode != MODE_IDLE);
    end

    assign o_state = n_st;

endmodule

FILE: hw/rtl/ps2_host_bit_engine.sv
// ps2 host bit engine top level: input register, line state and result register
// an accepted item is held in the input register, then its result in the result register drives the outputs
// throughput: one item per cycle, set by the combinational state update between the
// input register and the result register; a waiting result stalls the input only
// once the input register also holds an item
// reset: synchronous active-low i_rst_n sets the line idle, releases both lines,
// clears the pipeline and loads timeout 48 and inhibit 2 ticks
module ps2_host_bit_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic       i_data_level,
    input  logic [7:0] i_send_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_event_res,
    output logic [7:0] o_rx_byte,
    output logic       o_data_drive_low,
    output logic       o_clock_drive_low,
    output logic       o_busy_res
);
    import ps2hb_pkg::*;

    logic [7:0] r_timeout_ticks;
    logic [7:0] r_inhibit_ticks;
    logic       r_in_valid;
    logic [1:0] r_kind;
    logic       r_data_level;
    logic [7:0] r_send_byte;
    t_state     r_state;
    t_state     n_state;
    t_result    r_result;
    t_result    n_result;
    logic       r_out_valid;
    logic       w_adv;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= TIMEOUT_RESET;
            r_inhibit_ticks <= INHIBIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIMEOUT: r_timeout_ticks <= i_cfg_data;
                CFG_INHIBIT: r_inhibit_ticks <= i_cfg_data;
                default:     r_timeout_ticks <= r_timeout_ticks;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind       <= i_kind;
            r_data_level <= i_data_level;
            r_send_byte  <= i_send_byte;
        end
    end

    ps2hb_step u_step (
        .i_state         (r_state),
        .i_timeout_ticks (r_timeout_ticks),
        .i_inhibit_ticks (r_inhibit_ticks),
        .i_kind          (r_kind),
        .i_data_level    (r_data_level),
        .i_send_byte     (r_send_byte),
        .o_state         (n_state),
        .o_result        (n_result)
    );

    // line state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_event_res       = r_result.event_res;
    assign o_rx_byte         = r_result.rx_byte;
    assign o_data_drive_low  = r_result.data_drive_low;
    assign o_clock_drive_low = r_result.clock_drive_low;
    assign o_busy_res        = r_result.busy_res;

`ifndef SYNTH
    a_inhibit_holds_clock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == MODE_INHIBIT) |-> r_state.clock_low)
        else $error("clock released during inhibit");

    a_clock_only_inhibit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.clock_low |-> (r_state.mode == MODE_INHIBIT))
        else $error("clock held low outside inhibit");

    a_idle_no_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == MODE_IDLE) |-> (!r_state.timer_running && !r_state.data_low))
        else $error("idle line with timer running or data driven");

    a_trailer_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.in_trailer |-> (r_state.bit_mask == 8'd1 || r_state.bit_mask == 8'd2
                                || r_state.bit_mask == 8'd4))
        else $error("bad bit mask in frame tail");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_result.event_res == EV_SENT_ACK
                         || r_result.event_res == EV_SENT_NACK
                         || r_result.event_res == EV_TIMEOUT)) |-> !r_result.busy_res)
        else $error("busy after frame end");
`endif

endmodule

FILE: sim/tb_ps2_host_bit_engine.sv
// self-checking testbench for the ps2 host bit engine: directed and random event traffic
module tb_ps2_host_bit_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import ps2hb_pkg::*;

    localparam logic [1:0] KIND_UNDEF = 2'd3;
    localparam int FRAME_CLEAN = 0;
    localparam int FRAME_BAD_PARITY = 1;
    localparam int FRAME_BAD_STOP = 2;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 60;
    localparam int PRINT_LIMIT = 30;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_idx = CFG_TIMEOUT;
    logic [7:0] i_cfg_data = 8'd0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_kind = KIND_TICK;
    logic       i_data_level = 1'b0;
    logic [7:0] i_send_byte = 8'd0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [2:0] o_event_res;
    logic [7:0] o_rx_byte;
    logic       o_data_drive_low;
    logic       o_clock_drive_low;
    logic       o_busy_res;

    ps2_host_bit_engine dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_kind            (i_kind),
        .i_data_level      (i_data_level),
        .i_send_byte       (i_send_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_event_res       (o_event_res),
        .o_rx_byte         (o_rx_byte),
        .o_data_drive_low  (o_data_drive_low),
        .o_clock_drive_low (o_clock_drive_low),
        .o_busy_res        (o_busy_res)
    );

    always #10 i_clk = ~i_clk;

    // line model and its registers
    t_state     line_st = STATE_RESET;
    logic [7:0] timeout_reg = TIMEOUT_RESET;
    logic [7:0] inhibit_reg = INHIBIT_RESET;

    t_result expected_results[$];
    int items_accepted = 0;
    int results_seen = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int settings_used = 1;
    int event_tally[8] = '{default: 0};

    // sender and receiver pacing
    int burst_left = 0;
    int gap_max = 0;
    int tick_pct = 0;
    int hold_request = 0;
    int pace_left = 0;
    int pace_mode = 0;
    int stall_phase = 0;

    function automatic void line_to_idle();
        line_st.mode = MODE_IDLE;
        line_st.timer_running = 1'b0;
        line_st.idle_count = 8'd0;
        line_st.bit_mask = 8'd0;
        line_st.in_trailer = 1'b0;
        line_st.trailer_bits = 3'd0;
        line_st.data_low = 1'b0;
        line_st.clock_low = 1'b0;
    endfunction

    function automatic void restart_idle_timer();
        line_st.idle_count = 8'd0;
        line_st.timer_running = 1'b1;
    endfunction

    function automatic t_result predict_line_event(input logic [1:0] kind, input logic d,
                                                   input logic [7:0] sb);
        t_result    r;
        logic [2:0] ev;
        logic [7:0] rx;
        logic [7:0] held;
        logic       bit_v;
        logic       good;
        ev = EV_NONE;
        rx = 8'd0;
        case (kind)
            KIND_EDGE: begin
                if (line_st.mode == MODE_TX) begin
                    restart_idle_timer();
                    if (!line_st.in_trailer) begin
                        if (line_st.bit_mask == 8'd0) begin
                            line_st.parity_acc = 1'b0;
                            line_st.bit_mask = 8'd1;
                        end else begin
                            bit_v = |(line_st.frame_byte & line_st.bit_mask);
                            line_st.data_low = ~bit_v;
                            line_st.parity_acc ^= bit_v;
                            line_st.bit_mask = line_st.bit_mask << 1;
                            if (line_st.bit_mask == 8'd0) begin
                                line_st.in_trailer = 1'b1;
                                line_st.bit_mask = 8'd1;
                                line_st.trailer_bits = TRAILER_FIXED |
                                                       {2'b00, ~line_st.parity_acc};
                            end
                        end
                    end else begin
                        line_st.data_low = ~(|(line_st.trailer_bits & line_st.bit_mask[2:0]));
                        line_st.bit_mask = (line_st.bit_mask << 1) & 8'h07;
                        if (line_st.bit_mask == 8'd0) begin
                            line_to_idle();
                            ev = d ? EV_SENT_NACK : EV_SENT_ACK;
                        end
                    end
                end else if (line_st.mode == MODE_IDLE) begin
                    if (!d) begin
                        restart_idle_timer();
                        line_st.mode = MODE_RX;
                        line_st.frame_byte = 8'd0;
                        line_st.parity_acc = 1'b0;
                        line_st.bit_mask = 8'd1;
                        line_st.in_trailer = 1'b0;
                        line_st.trailer_bits = 3'd0;
                    end
                end else if (line_st.mode == MODE_RX) begin
                    restart_idle_timer();
                    if (!line_st.in_trailer) begin
                        if (d) line_st.frame_byte |= line_st.bit_mask;
                        line_st.parity_acc ^= d;
                        line_st.bit_mask = line_st.bit_mask << 1;
                        if (line_st.bit_mask == 8'd0) begin
                            line_st.in_trailer = 1'b1;
                            line_st.bit_mask = 8'd1;
                            line_st.trailer_bits = 3'd0;
                        end
                    end else if (line_st.bit_mask[0]) begin
                        if (d) line_st.trailer_bits[0] = 1'b1;
                        line_st.parity_acc ^= d;
                        line_st.bit_mask = 8'd2;
                    end else begin
                        good = d && line_st.parity_acc;
                        held = line_st.frame_byte;
                        line_to_idle();
                        if (good) begin
                            rx = held;
                            ev = (held == ACK_CODE) ? EV_ACKBYTE : EV_BYTE;
                        end
                    end
                end
            end
            KIND_TICK: begin
                if (line_st.timer_running) begin
                    if (line_st.idle_count < COUNT_MAX) line_st.idle_count += 8'd1;
                    if (line_st.mode == MODE_INHIBIT) begin
                        if (line_st.idle_count >= inhibit_reg) begin
                            line_st.data_low = 1'b1;
                            line_st.clock_low = 1'b0;
                            line_st.mode = MODE_TX;
                            line_st.bit_mask = 8'd0;
                            line_st.in_trailer = 1'b0;
                            line_st.parity_acc = 1'b0;
                            restart_idle_timer();
                        end
                    end else if (line_st.idle_count >= timeout_reg) begin
                        line_to_idle();
                        ev = EV_TIMEOUT;
                    end
                end
            end
            KIND_SEND: begin
                if (line_st.mode != MODE_IDLE) begin
                    ev = EV_REJECT;
                end else begin
                    line_st.frame_byte = sb;
                    line_st.mode = MODE_INHIBIT;
                    line_st.clock_low = 1'b1;
                    line_st.data_low = 1'b0;
                    line_st.bit_mask = 8'd0;
                    line_st.in_trailer = 1'b0;
                    line_st.trailer_bits = 3'd0;
                    line_st.parity_acc = 1'b0;
                    restart_idle_timer();
                end
            end
            default: ;
        endcase
        r.event_res = ev;
        r.rx_byte = rx;
        r.data_drive_low = line_st.data_low;
        r.clock_drive_low = line_st.clock_low;
        r.busy_res = (line_st.mode != MODE_IDLE);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t: result %0d %s expected %0d got %0d", $realtime, results_seen, what,
                     want, got);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped at cycle %0d with %0d results outstanding", cycle_count,
                     expected_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            expected_results.push_back(predict_line_event(i_kind, i_data_level, i_send_byte));
            items_accepted++;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            event_tally[o_event_res]++;
            if (expected_results.size() == 0) begin
                report_mismatch("arrived with nothing expected, event", EV_NONE, o_event_res);
            end else begin
                want = expected_results.pop_front();
                if (o_event_res !== want.event_res)
                    report_mismatch("event_res", want.event_res, o_event_res);
                if (o_rx_byte !== want.rx_byte)
                    report_mismatch("rx_byte", want.rx_byte, o_rx_byte);
                if (o_data_drive_low !== want.data_drive_low)
                    report_mismatch("data_drive_low", want.data_drive_low, o_data_drive_low);
                if (o_clock_drive_low !== want.clock_drive_low)
                    report_mismatch("clock_drive_low", want.clock_drive_low, o_clock_drive_low);
                if (o_busy_res !== want.busy_res)
                    report_mismatch("busy_res", want.busy_res, o_busy_res);
            end
        end
    end

    // result side: long hold-off on request, otherwise changing stall patterns
    always begin : result_pacing
        @(negedge i_clk);
        if (hold_request > 0) begin
            i_out_ready <= 1'b0;
            repeat (hold_request) @(negedge i_clk);
            hold_request = 0;
        end else begin
            if (pace_left == 0) begin
                pace_mode = $urandom_range(0, 3);
                pace_left = $urandom_range(10, 80);
            end
            pace_left--;
            stall_phase++;
            case (pace_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                2: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= (stall_phase % 4) != 3;
            endcase
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic d, input logic [7:0] sb);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                i_kind <= 2'($urandom);
                i_data_level <= 1'($urandom);
                i_send_byte <= 8'($urandom);
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_data_level <= d;
        i_send_byte <= sb;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic settle_line();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic write_register(input logic idx, input logic [7:0] value);
        settle_line();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        i_cfg_data <= 8'($urandom);
        if (idx == CFG_TIMEOUT) timeout_reg = value;
        else inhibit_reg = value;
        @(posedge i_clk);
    endtask

    task automatic set_ticks(input logic [7:0] timeout_v, input logic [7:0] inhibit_v);
        if ($urandom_range(0, 1)) begin
            write_register(CFG_TIMEOUT, timeout_v);
            write_register(CFG_INHIBIT, inhibit_v);
        end else begin
            write_register(CFG_INHIBIT, inhibit_v);
            write_register(CFG_TIMEOUT, timeout_v);
        end
        settings_used++;
    endtask

    // stray traffic between the edges of a frame
    task automatic between_edges();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < tick_pct)
            send_item(KIND_TICK, 1'($urandom), 8'($urandom));
        else if (pick < tick_pct + 2)
            send_item(KIND_SEND, 1'($urandom), 8'($urandom));
        else if (pick < tick_pct + 3)
            send_item(KIND_UNDEF, 1'($urandom), 8'($urandom));
    endtask

    task automatic receive_frame(input logic [7:0] value, input int fault);
        send_item(KIND_EDGE, 1'b0, 8'($urandom));
        for (int i = 0; i < 8; i++) begin
            between_edges();
            send_item(KIND_EDGE, value[i], 8'($urandom));
        end
        between_edges();
        send_item(KIND_EDGE, (~^value) ^ (fault == FRAME_BAD_PARITY), 8'($urandom));
        between_edges();
        send_item(KIND_EDGE, fault != FRAME_BAD_STOP, 8'($urandom));
    endtask

    task automatic send_frame(input logic [7:0] value, input logic ack_level);
        send_item(KIND_SEND, 1'($urandom), value);
        if ($urandom_range(0, 3) == 0) send_item(KIND_EDGE, 1'($urandom), 8'($urandom));
        repeat ((inhibit_reg == 8'd0) ? 1 : inhibit_reg)
            send_item(KIND_TICK, 1'($urandom), 8'($urandom));
        repeat (11) begin
            between_edges();
            send_item(KIND_EDGE, 1'($urandom), 8'($urandom));
        end
        send_item(KIND_EDGE, ack_level, 8'($urandom));
    endtask

    task automatic test_receive_directed();
        logic [7:0] ack;
        ack = ACK_CODE;
        tick_pct = 0;
        gap_max = 0;
        send_item(KIND_EDGE, 1'b0, 8'h00);
        for (int i = 0; i < 8; i++) begin
            if (i == 4) send_item(KIND_SEND, 1'b1, 8'hFF);
            send_item(KIND_EDGE, ack[i], 8'h00);
        end
        send_item(KIND_EDGE, ~^ack, 8'h00);
        send_item(KIND_EDGE, 1'b1, 8'h00);
        send_item(KIND_EDGE, 1'b1, 8'hFF);
        send_item(KIND_UNDEF, 1'b1, 8'hFF);
        receive_frame(8'h00, FRAME_BAD_PARITY);
        settle_line();
    endtask

    task automatic test_zero_wait_directed();
        set_ticks(8'd1, 8'd0);
        send_item(KIND_SEND, 1'b0, 8'h80);
        send_item(KIND_EDGE, 1'b0, 8'h00);
        send_item(KIND_TICK, 1'b0, 8'h00);
        send_item(KIND_TICK, 1'b1, 8'hFF);
        settle_line();
    endtask

    task automatic test_register_extremes();
        tick_pct = 0;
        gap_max = 3;
        set_ticks(8'hFF, 8'hFF);
        send_frame(8'h00, 1'b0);
        receive_frame(8'hFF, FRAME_CLEAN);
        send_item(KIND_EDGE, 1'b0, 8'h55);
        repeat (255) send_item(KIND_TICK, 1'($urandom), 8'($urandom));
        set_ticks(8'h00, 8'h00);
        receive_frame(8'h7E, FRAME_BAD_STOP);
        send_frame(8'hFF, 1'b1);
        settle_line();
    endtask

    task automatic test_output_backpressure();
        set_ticks(TIMEOUT_RESET, INHIBIT_RESET);
        gap_max = 0;
        tick_pct = 3;
        hold_request = $urandom_range(200, 400);
        repeat (3) receive_frame(8'($urandom), FRAME_CLEAN);
        send_frame(8'($urandom), 1'($urandom));
        settle_line();
    endtask

    task automatic test_random_traffic();
        logic [7:0] timeouts[6];
        logic [7:0] inhibits[6];
        int goal;
        int pick;
        logic [7:0] value;
        timeouts = '{TIMEOUT_RESET, 8'd1, 8'd0, 8'hFF, 8'd3, 8'd0};
        inhibits = '{INHIBIT_RESET, 8'd1, 8'd0, 8'd1, 8'd0, 8'd0};
        timeouts[5] = 8'($urandom_range(2, 40));
        inhibits[5] = 8'($urandom_range(1, 6));
        for (int p = 0; p < 6; p++) begin
            set_ticks(timeouts[p], inhibits[p]);
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            tick_pct = $urandom_range(0, 10);
            goal = items_accepted + PHASE_ITEMS;
            while (items_accepted < goal) begin
                pick = $urandom_range(0, 99);
                value = ($urandom_range(0, 9) == 0) ? ACK_CODE : 8'($urandom);
                if (pick < 30)
                    receive_frame(value, FRAME_CLEAN);
                else if (pick < 42)
                    receive_frame(value, $urandom_range(FRAME_BAD_PARITY, FRAME_BAD_STOP));
                else if (pick < 80)
                    send_frame(value, 1'($urandom));
                else begin
                    repeat ($urandom_range(1, 4))
                        send_item(2'($urandom), 1'($urandom), 8'($urandom));
                    if ($urandom_range(0, 1))
                        repeat (12) send_item(KIND_EDGE, 1'b1, 8'($urandom));
                end
            end
        end
        settle_line();
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_receive_directed();
        test_zero_wait_directed();
        test_register_extremes();
        test_output_backpressure();
        test_random_traffic();
        settle_line();
        repeat (8) @(posedge i_clk);
        $display("covered %0d items and %0d results across %0d tick settings", items_accepted,
                 results_seen, settings_used);
        $display("events: byte %0d, ack byte %0d, sent acked %0d, sent nacked %0d, %0s %0d, %0s %0d",
                 event_tally[EV_BYTE], event_tally[EV_ACKBYTE], event_tally[EV_SENT_ACK],
                 event_tally[EV_SENT_NACK], "timeout", event_tally[EV_TIMEOUT], "rejected",
                 event_tally[EV_REJECT]);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/ps2hb_pkg.sv
hw/rtl/ps2hb_step.sv
hw/rtl/ps2_host_bit_engine.sv
sim/tb_ps2_host_bit_engine.sv
